FILE: sv/tld_pkg.sv
// shared types and constants of the terminal input line discipline
package tld_pkg;

    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int CNT_W  = 7;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam byte_t CH_NUL  = 8'd0;
    localparam byte_t CH_BS   = 8'd8;
    localparam byte_t CH_NL   = 8'd10;
    localparam byte_t CH_CR   = 8'd13;
    localparam byte_t CH_DEL  = 8'd127;
    localparam byte_t CH_LOW  = 8'd32;
    localparam byte_t CH_HIGH = 8'd126;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_e;

    localparam logic [CFG_IDX_W-1:0] CFG_CRNL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO  = 2'd2;

    typedef struct packed {
        logic crnl;
        logic canon;
        logic echo;
    } cfg_t;

    typedef struct packed {
        logic  valid;
        kind_e kind;
        byte_t data;
        logic  last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUB_RD,
        ST_PUB_WR,
        ST_ECHO,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_e;

endpackage

FILE: sv/tld_ram.sv
// byte-wide single-port-read, single-port-write memory with registered read data
module tld_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  tld_pkg::byte_t    wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output tld_pkg::byte_t    rdata
);
    import tld_pkg::*;

    byte_t mem [DEPTH];
    byte_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tld_ctrl.sv
// command sequencer with line store and cooked ring memories
module tld_ctrl #(
    parameter int LINE_SLOTS   = 128,
    parameter int COOKED_SLOTS = 256,
    parameter int MAX_READ     = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tld_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  tld_pkg::byte_t      s_byte,
    input  tld_pkg::cnt_t       s_count,
    input  logic                out_free,
    output tld_pkg::res_t       res
);
    import tld_pkg::*;

    localparam int LW  = $clog2(LINE_SLOTS);
    localparam int LCW = $clog2(LINE_SLOTS + 1);
    localparam int RW  = $clog2(COOKED_SLOTS);
    localparam int RCW = $clog2(COOKED_SLOTS + 1);

    state_e state_reg, state_next;

    logic [1:0]   cmd_reg, cmd_next;
    byte_t        byte_reg, byte_next;
    cnt_t         cnt_reg, cnt_next;
    byte_t        echo_reg, echo_next;
    cnt_t         n_reg, n_next;
    logic [LCW-1:0] len_reg, len_next;
    logic [LCW-1:0] pub_len_reg, pub_len_next;
    logic [LCW-1:0] pub_idx_reg, pub_idx_next;
    logic [RW-1:0]  head_reg, head_next;
    logic [RCW-1:0] fill_reg, fill_next;

    // line store port
    logic          line_we, line_re;
    logic [LW-1:0] line_waddr, line_raddr;
    byte_t         line_wdata, line_rdata;
    // cooked ring port
    logic          ring_we, ring_re;
    logic [RW-1:0] ring_waddr, ring_raddr;
    byte_t         ring_wdata, ring_rdata;

    tld_ram #(.DEPTH(LINE_SLOTS), .AW(LW)) u_line (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    tld_ram #(.DEPTH(COOKED_SLOTS), .AW(RW)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // decoded byte command
    byte_t b_map;
    logic  b_nul, b_erase, b_nl, b_print, line_room, data_last;
    assign b_map     = (byte_reg == CH_CR && cfg.crnl) ? CH_NL : byte_reg;
    assign b_nul     = (byte_reg == CH_NUL);
    assign b_erase   = (b_map == CH_BS) || (b_map == CH_DEL);
    assign b_nl      = (b_map == CH_NL);
    assign b_print   = (b_map >= CH_LOW) && (b_map <= CH_HIGH);
    assign line_room = (len_reg < LCW'(LINE_SLOTS - 1));
    assign data_last = (ring_rdata == CH_NL) || (cnt_t'(n_reg + 1'b1) == cnt_reg);

    // ring push: a full ring drops its oldest byte first
    logic [RW-1:0]  head_inc, push_head, push_slot;
    logic [RCW-1:0] push_f, push_fill;
    logic [RCW:0]   push_sum;
    logic           push_full;
    assign head_inc  = (head_reg == RW'(COOKED_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign push_full = (fill_reg == RCW'(COOKED_SLOTS));
    assign push_head = push_full ? head_inc : head_reg;
    assign push_f    = push_full ? RCW'(COOKED_SLOTS - 1) : fill_reg;
    assign push_sum  = (RCW+1)'(push_head) + (RCW+1)'(push_f);
    assign push_slot = (push_sum >= (RCW+1)'(COOKED_SLOTS))
                     ? RW'(push_sum - (RCW+1)'(COOKED_SLOTS)) : RW'(push_sum);
    assign push_fill = push_f + 1'b1;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            head_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        byte_reg    <= byte_next;
        cnt_reg     <= cnt_next;
        echo_reg    <= echo_next;
        n_reg       <= n_next;
        pub_len_reg <= pub_len_next;
        pub_idx_reg <= pub_idx_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                unique case (cmd_reg)
                    CMD_BYTE: begin
                        priority if (b_nul) begin
                            state_next = ST_IDLE;
                        end else if (!cfg.canon) begin
                            state_next = cfg.echo ? ST_ECHO : ST_IDLE;
                        end else if (b_erase) begin
                            if (len_reg != '0 && cfg.echo) begin
                                state_next = ST_ECHO;
                            end
                        end else if (b_nl) begin
                            state_next = ST_PUB_RD;
                        end else if (b_print && line_room && cfg.echo) begin
                            state_next = ST_ECHO;
                        end
                    end
                    CMD_READ: begin
                        if (cnt_reg != '0) begin
                            state_next = ST_RD_ISSUE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PUB_RD: state_next = ST_PUB_WR;
            ST_PUB_WR: begin
                if (pub_idx_reg + 1'b1 == pub_len_reg) begin
                    state_next = cfg.echo ? ST_ECHO : ST_IDLE;
                end else begin
                    state_next = ST_PUB_RD;
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE: begin
                if (fill_reg != '0) begin
                    state_next = ST_RD_DATA;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_DATA: begin
                if (out_free) begin
                    state_next = data_last ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath, memory ports and results
    always_comb begin
        cmd_next     = cmd_reg;
        byte_next    = byte_reg;
        cnt_next     = cnt_reg;
        echo_next    = echo_reg;
        n_next       = n_reg;
        len_next     = len_reg;
        pub_len_next = pub_len_reg;
        pub_idx_next = pub_idx_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        line_we      = 1'b0;
        line_waddr   = len_reg[LW-1:0];
        line_wdata   = b_map;
        line_re      = 1'b0;
        line_raddr   = pub_idx_reg[LW-1:0];
        ring_we      = 1'b0;
        ring_waddr   = push_slot;
        ring_wdata   = b_map;
        ring_re      = 1'b0;
        ring_raddr   = head_reg;
        res          = '{valid: 1'b0, kind: KIND_ECHO, data: echo_reg, last: 1'b1};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_cmd;
                    byte_next = s_byte;
                    cnt_next  = (s_count > cnt_t'(MAX_READ)) ? cnt_t'(MAX_READ) : s_count;
                end
            end
            ST_DECODE: begin
                n_next = '0;
                unique case (cmd_reg)
                    CMD_BYTE: begin
                        priority if (b_nul) begin
                            n_next = '0;
                        end else if (!cfg.canon) begin
                            ring_we   = 1'b1;
                            head_next = push_head;
                            fill_next = push_fill;
                            echo_next = b_map;
                        end else if (b_erase) begin
                            if (len_reg != '0) begin
                                len_next  = len_reg - 1'b1;
                                echo_next = CH_BS;
                            end
                        end else if (b_nl) begin
                            line_wdata   = CH_NL;
                            pub_idx_next = '0;
                            echo_next    = CH_NL;
                            len_next     = '0;
                            if (len_reg < LCW'(LINE_SLOTS)) begin
                                line_we      = 1'b1;
                                pub_len_next = len_reg + 1'b1;
                            end else begin
                                pub_len_next = len_reg;
                            end
                        end else if (b_print && line_room) begin
                            line_we   = 1'b1;
                            len_next  = len_reg + 1'b1;
                            echo_next = b_map;
                        end
                    end
                    CMD_FLUSH: begin
                        head_next = '0;
                        fill_next = '0;
                        len_next  = '0;
                    end
                    default: n_next = '0;
                endcase
            end
            ST_PUB_RD: line_re = 1'b1;
            ST_PUB_WR: begin
                ring_we      = 1'b1;
                ring_wdata   = line_rdata;
                head_next    = push_head;
                fill_next    = push_fill;
                pub_idx_next = pub_idx_reg + 1'b1;
            end
            ST_ECHO: begin
                res.valid = out_free;
            end
            ST_RD_ISSUE: begin
                if (fill_reg != '0) begin
                    ring_re = 1'b1;
                end else begin
                    res = '{valid: out_free, kind: KIND_EMPTY, data: CH_NUL, last: 1'b1};
                end
            end
            ST_RD_DATA: begin
                res = '{valid: out_free, kind: KIND_DATA, data: ring_rdata, last: data_last};
                if (out_free) begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                    n_next    = n_reg + 1'b1;
                end
            end
            default: n_next = n_reg;
        endcase
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= RCW'(COOKED_SLOTS))
        else $error("ring fill above capacity");
    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (RW+1)'(head_reg) < (RW+1)'(COOKED_SLOTS))
        else $error("ring head out of range");
    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LCW'(LINE_SLOTS - 1))
        else $error("line length above limit");
    a_res_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> out_free)
        else $error("result issued into a busy output register");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_DATA) |-> $past(fill_reg) != '0)
        else $error("ring read issued on empty ring");
`endif

endmodule

FILE: sv/tty_line_discipline.sv
// top level of the terminal input line discipline: config registers and output register
//
// channel  dir  handshake               payload
// s_       in   s_tvalid / s_tready     tuser: cmd; tdata: in_byte, read_count
// m_       out  m_tvalid / m_tready     tuser: kind; tdata: out_byte; tlast: last
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a request is taken in ST_IDLE and decoded in the next cycle; an echo then passes ST_ECHO
// newline publishes the line byte by byte, each a line store read, then a ring write
// a read request pops ring bytes one at a time via the ring read port, stalling on a busy output
// reset clears pointers, lengths, flags and sets modes; the two memories need no clearing pass
// a result waits while the output register is full and m_tready is low; no request is taken then
module tty_line_discipline #(
    parameter int LINE_SLOTS   = 128,
    parameter int COOKED_SLOTS = 256,
    parameter int MAX_READ     = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // in_byte [7:0], read_count [14:8], zero [15]
    input  logic [1:0]  s_tuser,    // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte [7:0]
    output logic [1:0]  m_tuser,    // kind [1:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    import tld_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  m_valid_reg, m_valid_next;
    res_t  out_reg, out_next;
    res_t  res;
    logic  out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CRNL:  cfg_next.crnl  = cfg_data;
                CFG_CANON: cfg_next.canon = cfg_data;
                CFG_ECHO:  cfg_next.echo  = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        out_next     = res.valid ? res : out_reg;
        m_valid_next = res.valid || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '{crnl: 1'b1, canon: 1'b1, echo: 1'b1};
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    tld_ctrl #(
        .LINE_SLOTS   (LINE_SLOTS),
        .COOKED_SLOTS (COOKED_SLOTS),
        .MAX_READ     (MAX_READ)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_cmd    (s_tuser),
        .s_byte   (s_tdata[7:0]),
        .s_count  (s_tdata[14:8]),
        .out_free (out_free),
        .res      (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

FILE: dv/tb_tty_line_discipline.sv
// self-checking testbench of the terminal input line discipline with its own line and ring model
module tb_tty_line_discipline;
    import tld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_SLOTS    = 128;
    localparam int COOKED_SLOTS  = 256;
    localparam int MAX_READ      = 64;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 30;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        byte_t            ch;
        cnt_t             count;
    } req_t;

    typedef struct packed {
        kind_e kind;
        byte_t ch;
        logic  last;
    } reply_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_CRNL;
    logic        cfg_data  = 1'b0;

    tty_line_discipline #(
        .LINE_SLOTS  (LINE_SLOTS),
        .COOKED_SLOTS(COOKED_SLOTS),
        .MAX_READ    (MAX_READ)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // model of the line store, the cooked ring and the mode registers
    cfg_t   mode;
    byte_t  line_mem [LINE_SLOTS];
    int     line_used;
    byte_t  ring_mem [COOKED_SLOTS];
    int     ring_rd;
    int     ring_cnt;

    req_t   pending_q [$];
    reply_t awaited_out [$];
    req_t   cur_req;
    int     n_queued;
    int     n_accepted;
    int     n_errors;
    int     src_gap;
    int     stall_left;
    int     cycle_count;
    bit     calm;
    bit     hold_armed;
    bit     hold_taken;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void emit(kind_e k, byte_t ch, logic lst);
        reply_t r;
        r.kind = k;
        r.ch   = ch;
        r.last = lst;
        awaited_out.push_back(r);
    endfunction

    function automatic void ring_put(byte_t ch);
        // a full ring loses its oldest byte
        if (ring_cnt >= COOKED_SLOTS) begin
            ring_rd  = (ring_rd + 1) % COOKED_SLOTS;
            ring_cnt = COOKED_SLOTS - 1;
        end
        ring_mem[(ring_rd + ring_cnt) % COOKED_SLOTS] = ch;
        ring_cnt++;
    endfunction

    function automatic void run_discipline(req_t rq);
        byte_t ch;
        int    lim;
        int    got;
        ch = rq.ch;
        case (rq.cmd)
            CMD_BYTE: begin
                if (ch == CH_NUL) return;
                if (ch == CH_CR && mode.crnl) ch = CH_NL;
                if (!mode.canon) begin
                    ring_put(ch);
                    if (mode.echo) emit(KIND_ECHO, ch, 1'b1);
                    return;
                end
                if (ch == CH_BS || ch == CH_DEL) begin
                    if (line_used == 0) return;
                    line_used--;
                    if (mode.echo) emit(KIND_ECHO, CH_BS, 1'b1);
                    return;
                end
                if (ch == CH_NL) begin
                    if (line_used < LINE_SLOTS) begin
                        line_mem[line_used] = CH_NL;
                        line_used++;
                    end
                    for (int i = 0; i < line_used; i++) ring_put(line_mem[i]);
                    line_used = 0;
                    if (mode.echo) emit(KIND_ECHO, CH_NL, 1'b1);
                    return;
                end
                if (ch < CH_LOW || ch > CH_HIGH) return;
                // last slot of the line is kept for the newline
                if (line_used >= LINE_SLOTS - 1) return;
                line_mem[line_used] = ch;
                line_used++;
                if (mode.echo) emit(KIND_ECHO, ch, 1'b1);
            end
            CMD_READ: begin
                lim = rq.count;
                if (lim == 0) return;
                if (lim > MAX_READ) lim = MAX_READ;
                got = 0;
                while (got < lim) begin
                    if (ring_cnt == 0) begin
                        emit(KIND_EMPTY, CH_NUL, 1'b1);
                        return;
                    end
                    ch = ring_mem[ring_rd];
                    ring_rd = (ring_rd + 1) % COOKED_SLOTS;
                    ring_cnt--;
                    emit(KIND_DATA, ch, 1'b0);
                    got++;
                    if (ch == CH_NL) break;
                end
                awaited_out[awaited_out.size() - 1].last = 1'b1;
            end
            CMD_FLUSH: begin
                ring_rd  = 0;
                ring_cnt = 0;
                line_used = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void push_req(logic [CMD_W-1:0] cmd, byte_t ch, cnt_t count);
        req_t rq;
        rq.cmd   = cmd;
        rq.ch    = ch;
        rq.count = count;
        pending_q.push_back(rq);
        n_queued++;
    endfunction

    function automatic void push_byte(byte_t ch);
        push_req(CMD_BYTE, ch, cnt_t'($urandom_range(0, 127)));
    endfunction

    function automatic void push_read(cnt_t count);
        push_req(CMD_READ, byte_t'($urandom_range(0, 255)), count);
    endfunction

    // printable text, optionally with erases and stray bytes, ended by newline or return
    function automatic void push_line(int len, bit noisy);
        int r;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (noisy && r < 10)
                push_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            else if (noisy && r < 15)
                push_byte(byte_t'($urandom_range(0, 255)));
            else
                push_byte(byte_t'($urandom_range(CH_LOW, CH_HIGH)));
        end
        push_byte($urandom_range(0, 1) ? CH_NL : CH_CR);
    endfunction

    function automatic void push_mix(int n);
        int stop;
        int r;
        stop = n_queued + n;
        while (n_queued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                push_line($urandom_range(0, 10), 1'b1);
            else if (r < 65)
                push_read(cnt_t'($urandom_range(1, MAX_READ)));
            else if (r < 80)
                push_read(cnt_t'($urandom_range(0, 127)));
            else if (r < 90)
                push_byte(byte_t'($urandom_range(0, 255)));
            else if (r < 95)
                push_req(CMD_FLUSH, byte_t'($urandom_range(0, 255)),
                         cnt_t'($urandom_range(0, 127)));
            else
                push_req(CMD_UNUSED, byte_t'($urandom_range(0, 255)),
                         cnt_t'($urandom_range(0, 127)));
        end
    endfunction

    task automatic drain();
        do @(posedge aclk);
        while (!(n_accepted == n_queued && awaited_out.size() == 0 && !s_tvalid));
    endtask

    // an ignored byte or a publish with echo off leaves no trace on the output
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_CRNL:  mode.crnl  = val;
            CFG_CANON: mode.canon = val;
            default:   mode.echo  = val;
        endcase
    endtask

    task automatic set_mode(input logic crnl, input logic canon, input logic echo_on);
        write_reg(CFG_CRNL, crnl);
        write_reg(CFG_CANON, canon);
        write_reg(CFG_ECHO, echo_on);
        cfg_valid <= 1'b0;
    endtask

    // request driver, predicts each request as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                run_discipline(cur_req);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_req = pending_q.pop_front();
                    s_tuser  <= cur_req.cmd;
                    s_tdata  <= {1'b0, cur_req.count, cur_req.ch};
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls: short random bursts, one long hold when armed
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_out.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: expected none, got kind %0d byte %02h last %0b",
                             $time, m_tuser, m_tdata, m_tlast);
            end else begin
                want = awaited_out.pop_front();
                if (m_tuser !== want.kind || m_tdata !== want.ch || m_tlast !== want.last) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t ns: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                 $time, want.kind, want.ch, want.last,
                                 m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tty_line_discipline: mismatch");
            $finish;
        end
    end

    initial begin
        mode       = '{crnl: 1'b1, canon: 1'b1, echo: 1'b1};
        line_used  = 0;
        ring_rd    = 0;
        ring_cnt   = 0;
        n_queued   = 0;
        n_accepted = 0;
        n_errors   = 0;
        src_gap    = 0;
        stall_left = 0;
        cycle_count = 0;
        calm       = 1'b0;
        hold_armed = 1'b0;
        hold_taken = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset modes: nul, erase on empty line, read of empty ring
        push_byte(CH_NUL);
        push_byte(CH_BS);
        push_read(cnt_t'(5));
        // edges of the printable range, both erase codes, ignored controls, return as newline
        push_byte(8'h61);
        push_byte(CH_LOW);
        push_byte(CH_HIGH);
        push_byte(CH_DEL);
        push_byte(8'h1f);
        push_byte(8'h80);
        push_byte(8'hff);
        push_byte(CH_BS);
        push_byte(8'h5a);
        push_byte(CH_CR);
        // zero count, short count, saturated count stopping at newline, ring run dry
        push_read(cnt_t'(0));
        push_read(cnt_t'(2));
        push_read(cnt_t'(127));
        push_read(cnt_t'(1));
        // flush clears the ring, then the pending line
        push_byte(8'h78);
        push_byte(CH_NL);
        push_req(CMD_FLUSH, 8'hff, cnt_t'(127));
        push_read(cnt_t'(3));
        push_req(CMD_UNUSED, 8'hff, cnt_t'(127));
        push_byte(8'h79);
        push_req(CMD_FLUSH, 8'h00, cnt_t'(0));
        push_byte(CH_NL);
        push_read(cnt_t'(MAX_READ));
        settle();

        // receiver holds off while lines and reads keep coming, then a sender pause
        set_mode(1'b1, 1'b1, 1'b1);
        hold_armed = 1'b1;
        repeat (3) push_line(8, 1'b1);
        repeat (3) push_read(cnt_t'(MAX_READ));
        push_mix(20);
        drain();
        push_mix(20);
        settle();

        // full line, then enough lines to overrun the ring
        push_line(LINE_SLOTS + 2, 1'b0);
        push_line(LINE_SLOTS + 2, 1'b0);
        push_line(2, 1'b0);
        repeat (6) push_read(cnt_t'(MAX_READ));
        settle();

        set_mode(1'b0, 1'b1, 1'b1);
        push_mix(15);
        settle();
        set_mode(1'b1, 1'b0, 1'b1);
        push_mix(15);
        settle();
        set_mode(1'b0, 1'b0, 1'b0);
        push_mix(15);
        settle();
        set_mode(1'b1, 1'b1, 1'b0);
        push_mix(15);
        settle();
        set_mode(1'b0, 1'b0, 1'b1);
        push_mix(15);
        settle();

        // last stretch runs at full rate on both sides
        set_mode(1'b1, 1'b1, 1'b1);
        calm = 1'b1;
        push_mix(30);
        settle();

        if (n_errors == 0)
            $display("tty_line_discipline: match");
        else
            $display("tty_line_discipline: mismatch");
        $finish;
    end

endmodule
